/* rtl/core/clcd_pkg.sv */
// shared types, codes and command bytes for the character lcd buffer controller
// no dependencies; imported by clcd_ram and char_lcd_buffer_controller_top
package clcd_pkg;

  localparam int MAX_COLUMNS_DEF = 20;
  localparam int MAX_ROWS_DEF    = 4;

  localparam int COL_W     = 5;
  localparam int ROW_W     = 2;
  localparam int CUR_ROW_W = 3;
  localparam int STEP_W    = 4;

  localparam logic [2:0] KIND_INIT       = 3'd0;
  localparam logic [2:0] KIND_CLEAR      = 3'd1;
  localparam logic [2:0] KIND_SET_CURSOR = 3'd2;
  localparam logic [2:0] KIND_PUT        = 3'd3;
  localparam logic [2:0] KIND_REFRESH    = 3'd4;

  localparam logic [1:0] STATUS_XFER     = 2'd0;
  localparam logic [1:0] STATUS_PAST_END = 2'd1;
  localparam logic [1:0] STATUS_COL_OOR  = 2'd2;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_BUS4    = 2'd2;

  localparam logic [7:0] CMD_FUNCTION_SET = 8'h20;
  localparam logic [7:0] FSET_8BIT        = 8'h10;
  localparam logic [7:0] FSET_TWO_LINE    = 8'h08;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_HOME         = 8'h02;
  localparam logic [7:0] CMD_DDRAM        = 8'h80;
  localparam logic [7:0] DDRAM_ROW1       = 8'h40;
  localparam logic [7:0] WAKE_NIBBLE      = 8'h03;
  localparam logic [7:0] WAKE_LAST_NIBBLE = 8'h02;
  localparam logic [7:0] CHAR_SPACE       = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;

  // init sequence: steps 0..3 wake-up, 4..8 setup bytes
  localparam logic [STEP_W-1:0] INIT_FIRST_SETUP = 4'd4;
  localparam logic [STEP_W-1:0] INIT_LAST_WAKE   = 4'd3;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP   = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CMD,
    ST_DATA,
    ST_FLAG
  } state_t;

  function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] step,
                                           input logic [7:0] fset);
    logic [7:0] b;
    case (step)
      4'd5:    b = CMD_DISPLAY_ON;
      4'd6:    b = CMD_CLEAR;
      4'd7:    b = CMD_ENTRY_MODE;
      4'd8:    b = CMD_HOME;
      default: b = fset;
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/clcd_ram.sv */
// generic single write port ram with registered read
// uses clcd_pkg for the default depth, MAX_COLUMNS_DEF * MAX_ROWS_DEF
module clcd_ram
  import clcd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = MAX_COLUMNS_DEF * MAX_ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/char_lcd_buffer_controller_top.sv */
// character lcd buffer controller: request sequencer, cursor and character store
// depends on clcd_pkg and clcd_ram
//
// usage
//   requests enter on the in channel (in_valid / in_stall), one word per request:
//   kind, column, row, character. bus transfers and flags leave on the out channel
//   (out_valid / out_stall), one word per transfer, final_res on the last word of
//   a request. configuration is written through cfg_write / cfg_index / cfg_data
//   while the block is idle; the user must ensure this, the block does not.
//   in_stall is high while a request is being worked on. clear, set cursor and
//   put char are done in the idle state; a flag adds one word via the flag state.
//   init sends 8 words (8-bit bus) or 14 words (4-bit bus), refresh up to
//   2 + 2*columns words, 42 for a 20 column row. the sequencer loads one word a
//   cycle into the output register while the receiver does not stall; a refresh
//   reads the single store read port one column per byte. when the receiver stalls
//   the output register holds and the sequencer waits. reset clears the cursor,
//   the config to 16 columns, 2 rows, 4-bit bus, and all store fill flags at once,
//   so every cell reads as a space straight away.
module char_lcd_buffer_controller_top
  import clcd_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       kind,
  input  logic [COL_W-1:0] column,
  input  logic [ROW_W-1:0] row,
  input  logic [7:0]       character,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             register_select,
  output logic [7:0]       bus_value,
  output logic             half,
  output logic [1:0]       status,
  output logic             final_res,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [COL_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  state_t               state, state_next;
  logic [STEP_W-1:0]    step, step_next;
  logic                 phase, phase_next;
  logic [COL_W-1:0]     col_idx, col_idx_next;
  logic [ROW_W-1:0]     item_row, item_row_next;
  logic [1:0]           flag_code, flag_code_next;
  logic [COL_W-1:0]     cursor_col, cursor_col_next;
  logic [CUR_ROW_W-1:0] cursor_row, cursor_row_next;
  logic                 stopped, stopped_next;
  logic [DEPTH-1:0]     filled, filled_next;
  logic                 rd_filled;

  logic [COL_W-1:0]     column_count;
  logic [CUR_ROW_W-1:0] row_count;
  logic                 four_bit_bus;
  logic [COL_W-1:0]     eff_cols;
  logic [CUR_ROW_W-1:0] eff_rows;

  logic                 out_valid_next;
  logic                 rs_next, half_next, final_next;
  logic [7:0]           bus_next;
  logic [1:0]           status_next;

  logic                 slot_free, wr_en, use_cursor, single, done, last;
  logic [7:0]           fset, xfer_byte, rd_data, char_byte;
  logic                 xfer_rs;
  logic [CUR_ROW_W-1:0] sel_row;
  logic [COL_W-1:0]     sel_col;
  logic [ADDR_W-1:0]    addr;

  clcd_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(addr),
    .wr_data(character),
    .rd_addr(addr),
    .rd_data(rd_data)
  );

  assign in_stall  = (state != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign char_byte = rd_filled ? rd_data : CHAR_SPACE;

  always_comb begin
    if (column_count == '0) begin
      eff_cols = COL_W'(1);
    end else if (column_count > COL_W'(MAX_COLUMNS)) begin
      eff_cols = COL_W'(MAX_COLUMNS);
    end else begin
      eff_cols = column_count;
    end
    if (row_count == '0) begin
      eff_rows = CUR_ROW_W'(1);
    end else if (row_count > CUR_ROW_W'(MAX_ROWS)) begin
      eff_rows = CUR_ROW_W'(MAX_ROWS);
    end else begin
      eff_rows = row_count;
    end
    fset = CMD_FUNCTION_SET | (four_bit_bus ? 8'h00 : FSET_8BIT)
         | ((eff_rows > CUR_ROW_W'(1)) ? FSET_TWO_LINE : 8'h00);
  end

  // current transfer of the sequencer
  always_comb begin
    xfer_byte = 8'h00;
    xfer_rs   = 1'b0;
    single    = 1'b0;
    last      = 1'b0;
    case (state)
      ST_INIT: begin
        if (four_bit_bus && step <= INIT_LAST_WAKE) begin
          single    = 1'b1;
          xfer_byte = (step == INIT_LAST_WAKE) ? WAKE_LAST_NIBBLE : WAKE_NIBBLE;
        end else if (step < INIT_FIRST_SETUP) begin
          xfer_byte = fset;
        end else begin
          xfer_byte = init_byte(step, fset);
        end
        last = (step == INIT_LAST_STEP);
      end
      ST_CMD: begin
        xfer_byte = item_row[0] ? (CMD_DDRAM | DDRAM_ROW1) : CMD_DDRAM;
      end
      ST_DATA: begin
        xfer_byte = char_byte;
        xfer_rs   = 1'b1;
        last      = (col_idx == eff_cols - COL_W'(1));
      end
      ST_FLAG: begin
        last = 1'b1;
      end
      default: ;
    endcase
    done = single || !four_bit_bus || phase;
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    phase_next      = phase;
    col_idx_next    = col_idx;
    item_row_next   = item_row;
    flag_code_next  = flag_code;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    stopped_next    = stopped;
    filled_next     = filled;
    wr_en           = 1'b0;
    out_valid_next  = out_valid && out_stall;
    rs_next         = register_select;
    bus_next        = bus_value;
    half_next       = half;
    status_next     = status;
    final_next      = final_res;

    if (state == ST_IDLE) begin
      if (in_valid) begin
        case (kind)
          KIND_INIT: begin
            filled_next     = '0;
            cursor_col_next = '0;
            cursor_row_next = '0;
            stopped_next    = 1'b0;
            step_next       = four_bit_bus ? STEP_W'(0) : STEP_W'(1);
            phase_next      = 1'b0;
            state_next      = ST_INIT;
          end
          KIND_CLEAR: begin
            filled_next = '0;
          end
          KIND_SET_CURSOR: begin
            if (column >= eff_cols) begin
              flag_code_next = STATUS_COL_OOR;
              stopped_next   = 1'b1;
              state_next     = ST_FLAG;
            end else begin
              cursor_col_next = column;
              cursor_row_next = {1'b0, row};
              stopped_next    = 1'b0;
            end
          end
          KIND_PUT: begin
            if (!stopped) begin
              if (character == CHAR_NEWLINE) begin
                cursor_col_next = '0;
                if (cursor_row != '1) begin
                  cursor_row_next = cursor_row + CUR_ROW_W'(1);
                end
              end else if (cursor_row >= eff_rows) begin
                flag_code_next = STATUS_PAST_END;
                stopped_next   = 1'b1;
                state_next     = ST_FLAG;
              end else if (cursor_col >= eff_cols) begin
                flag_code_next = STATUS_COL_OOR;
                stopped_next   = 1'b1;
                state_next     = ST_FLAG;
              end else begin
                wr_en = 1'b1;
                if (cursor_col + COL_W'(1) >= eff_cols) begin
                  cursor_col_next = '0;
                  if (cursor_row != '1) begin
                    cursor_row_next = cursor_row + CUR_ROW_W'(1);
                  end
                end else begin
                  cursor_col_next = cursor_col + COL_W'(1);
                end
              end
            end
          end
          KIND_REFRESH: begin
            if ({1'b0, row} < eff_rows) begin
              item_row_next = row;
              col_idx_next  = '0;
              phase_next    = 1'b0;
              state_next    = (row < ROW_W'(2)) ? ST_CMD : ST_DATA;
            end
          end
          default: ;
        endcase
      end
    end else if (slot_free) begin
      out_valid_next = 1'b1;
      final_next     = last && (done || state == ST_FLAG);
      if (state == ST_FLAG) begin
        rs_next     = 1'b0;
        bus_next    = 8'h00;
        half_next   = 1'b0;
        status_next = flag_code;
        state_next  = ST_IDLE;
      end else begin
        rs_next     = xfer_rs;
        status_next = STATUS_XFER;
        if (single) begin
          bus_next  = {4'h0, xfer_byte[3:0]};
          half_next = 1'b1;
        end else if (four_bit_bus) begin
          bus_next  = phase ? {4'h0, xfer_byte[3:0]} : {4'h0, xfer_byte[7:4]};
          half_next = 1'b1;
        end else begin
          bus_next  = xfer_byte;
          half_next = 1'b0;
        end
        phase_next = !done;
        if (done) begin
          case (state)
            ST_INIT: begin
              if (last) begin
                state_next = ST_IDLE;
              end else begin
                step_next = step + STEP_W'(1);
              end
            end
            ST_CMD: begin
              state_next = ST_DATA;
            end
            ST_DATA: begin
              if (last) begin
                state_next = ST_IDLE;
              end else begin
                col_idx_next = col_idx + COL_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
    end

    // one address unit serves the put write and the refresh read
    use_cursor = (state == ST_IDLE) && !(in_valid && kind == KIND_REFRESH);
    sel_row    = use_cursor ? cursor_row : {1'b0, item_row_next};
    sel_col    = use_cursor ? cursor_col : col_idx_next;
    addr       = ADDR_W'(int'(sel_row) * MAX_COLUMNS + int'(sel_col));
    if (wr_en) begin
      filled_next[addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      phase        <= 1'b0;
      col_idx      <= '0;
      item_row     <= '0;
      flag_code    <= STATUS_XFER;
      cursor_col   <= '0;
      cursor_row   <= '0;
      stopped      <= 1'b0;
      filled       <= '0;
      out_valid    <= 1'b0;
      column_count <= COL_W'(16);
      row_count    <= CUR_ROW_W'(2);
      four_bit_bus <= 1'b1;
    end else begin
      state      <= state_next;
      step       <= step_next;
      phase      <= phase_next;
      col_idx    <= col_idx_next;
      item_row   <= item_row_next;
      flag_code  <= flag_code_next;
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      stopped    <= stopped_next;
      filled     <= filled_next;
      out_valid  <= out_valid_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_COLUMNS: column_count <= cfg_data;
          REG_ROWS:    row_count    <= cfg_data[CUR_ROW_W-1:0];
          REG_BUS4:    four_bit_bus <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    register_select <= rs_next;
    bus_value       <= bus_next;
    half            <= half_next;
    status          <= status_next;
    final_res       <= final_next;
    rd_filled       <= filled[addr];
  end

  a_flag_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_XFER |-> final_res && !half && bus_value == 8'h00)
    else $error("flag word is not a lone final word");

  a_nibble_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && half |-> bus_value[7:4] == 4'h0)
    else $error("nibble word carries high bits");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && state == ST_IDLE)
    else $error("block not idle after reset");

endmodule

/* tb/sv/char_lcd_buffer_controller_top_tb.sv */
// self-checking testbench for char_lcd_buffer_controller_top: directed table, then random
// requests over several register settings, every bus word compared with a local predictor
// depends on clcd_pkg and the controller rtl only
module char_lcd_buffer_controller_top_tb;
  import clcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_UNUSED_LO  = 3'd5;
  localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI  = 3'd7;

  localparam int PREDICTED = -1;
  localparam int NO_WORDS  = 0;
  localparam int ONE_FLAG  = 1;

  localparam int NUM_OPENING     = 25;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 35;
  localparam int CALM_PHASE      = 4;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 20;
  localparam int MAX_PRINTED     = 100;

  typedef struct packed {
    logic       rs;
    logic [7:0] val;
    logic       hf;
    logic [1:0] st;
    logic       fin;
  } lcd_word_t;

  typedef struct {
    logic [2:0] kind;
    logic [4:0] column;
    logic [1:0] row;
    logic [7:0] character;
    int         typed;
    logic [1:0] flag;
  } directed_req_t;

  typedef struct {
    logic [4:0] cols;
    logic [2:0] rows;
    logic       four;
  } phase_cfg_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [2:0]       kind = KIND_CLEAR;
  logic [COL_W-1:0] column = '0;
  logic [ROW_W-1:0] row = '0;
  logic [7:0]       character = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             register_select;
  logic [7:0]       bus_value;
  logic             half;
  logic [1:0]       status;
  logic             final_res;
  logic             cfg_write = 1'b0;
  logic [1:0]       cfg_index = REG_COLUMNS;
  logic [COL_W-1:0] cfg_data = '0;
  logic             calm = 1'b0;

  // predictor state
  logic [7:0] char_cells [MAX_ROWS_DEF*MAX_COLUMNS_DEF];
  logic [4:0] cur_col;
  logic [2:0] cur_row;
  logic       stopped;
  logic [4:0] cfg_cols;
  logic [2:0] cfg_rows;
  logic       cfg_four;

  lcd_word_t step_words[$];
  lcd_word_t expected_words[$];
  int        mismatch_count = 0;

  directed_req_t opening_reqs [NUM_OPENING];
  phase_cfg_t    phases [NUM_PHASES];

  char_lcd_buffer_controller_top u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .column          (column),
    .row             (row),
    .character       (character),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .register_select (register_select),
    .bus_value       (bus_value),
    .half            (half),
    .status          (status),
    .final_res       (final_res),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int unsigned cols_in_use();
    if (cfg_cols == 0) return 1;
    if (cfg_cols > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return cfg_cols;
  endfunction

  function automatic int unsigned rows_in_use();
    if (cfg_rows == 0) return 1;
    if (cfg_rows > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return cfg_rows;
  endfunction

  function automatic void blank_cells();
    foreach (char_cells[i]) char_cells[i] = CHAR_SPACE;
  endfunction

  function automatic void reset_model();
    blank_cells();
    cur_col  = '0;
    cur_row  = '0;
    stopped  = 1'b0;
    cfg_cols = 5'd16;
    cfg_rows = 3'd2;
    cfg_four = 1'b1;
  endfunction

  function automatic void add_word(logic rs, logic [7:0] val, logic hf, logic [1:0] st);
    step_words.push_back('{rs, val, hf, st, 1'b0});
  endfunction

  function automatic void add_byte(logic rs, logic [7:0] val);
    if (cfg_four) begin
      add_word(rs, {4'h0, val[7:4]}, 1'b1, STATUS_XFER);
      add_word(rs, {4'h0, val[3:0]}, 1'b1, STATUS_XFER);
    end else begin
      add_word(rs, val, 1'b0, STATUS_XFER);
    end
  endfunction

  function automatic void add_flag(logic [1:0] st);
    add_word(1'b0, 8'h00, 1'b0, st);
    stopped = 1'b1;
  endfunction

  function automatic void advance_row();
    cur_col = '0;
    if (cur_row < 3'd7) cur_row = cur_row + 3'd1;
  endfunction

  // works out the bus words of one request and updates the local state
  function automatic void predict_lcd_words(logic [2:0] k, logic [4:0] c, logic [1:0] r,
                                            logic [7:0] ch);
    logic [7:0]  fset;
    int unsigned cols;
    cols = cols_in_use();
    step_words.delete();
    case (k)
      KIND_INIT: begin
        fset = CMD_FUNCTION_SET;
        if (!cfg_four) fset = fset | FSET_8BIT;
        if (rows_in_use() > 1) fset = fset | FSET_TWO_LINE;
        blank_cells();
        cur_col = '0;
        cur_row = '0;
        stopped = 1'b0;
        if (cfg_four) begin
          repeat (3) add_word(1'b0, WAKE_NIBBLE, 1'b1, STATUS_XFER);
          add_word(1'b0, WAKE_LAST_NIBBLE, 1'b1, STATUS_XFER);
        end else begin
          repeat (3) add_byte(1'b0, fset);
        end
        add_byte(1'b0, fset);
        add_byte(1'b0, CMD_DISPLAY_ON);
        add_byte(1'b0, CMD_CLEAR);
        add_byte(1'b0, CMD_ENTRY_MODE);
        add_byte(1'b0, CMD_HOME);
      end
      KIND_CLEAR: blank_cells();
      KIND_SET_CURSOR: begin
        if (c >= cols) begin
          add_flag(STATUS_COL_OOR);
        end else begin
          cur_col = c;
          cur_row = {1'b0, r};
          stopped = 1'b0;
        end
      end
      KIND_PUT: begin
        if (stopped) begin
        end else if (ch == CHAR_NEWLINE) begin
          advance_row();
        end else if (cur_row >= rows_in_use()) begin
          add_flag(STATUS_PAST_END);
        end else if (cur_col >= cols) begin
          add_flag(STATUS_COL_OOR);
        end else begin
          char_cells[cur_row*MAX_COLUMNS_DEF + cur_col] = ch;
          cur_col = cur_col + 5'd1;
          if (cur_col >= cols) advance_row();
        end
      end
      KIND_REFRESH: begin
        if (r < rows_in_use()) begin
          if (r == 0) add_byte(1'b0, CMD_DDRAM);
          else if (r == 1) add_byte(1'b0, CMD_DDRAM | DDRAM_ROW1);
          for (int i = 0; i < cols; i++) add_byte(1'b1, char_cells[r*MAX_COLUMNS_DEF + i]);
        end
      end
      default: begin
      end
    endcase
    if (step_words.size() > 0) step_words[step_words.size()-1].fin = 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) $display("%0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [2:0] k, input logic [4:0] c, input logic [1:0] r,
                              input logic [7:0] ch, input int typed, input logic [1:0] flag);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    column    <= c;
    row       <= r;
    character <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_lcd_words(k, c, r, ch);
    if (typed == PREDICTED) begin
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
    end else if (typed == ONE_FLAG) begin
      expected_words.push_back('{1'b0, 8'h00, 1'b0, flag, 1'b1});
    end
  endtask

  // a request with no words may still be in flight once the queue is empty
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_COLUMNS: cfg_cols = val;
      REG_ROWS:    cfg_rows = val[2:0];
      REG_BUS4:    cfg_four = val[0];
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 7);
  end

  always @(posedge clk) begin
    lcd_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word rs=%0d bus=%02h half=%0d status=%0d final=%0d",
                                  register_select, bus_value, half, status, final_res));
      end else begin
        want = expected_words.pop_front();
        if (register_select !== want.rs)
          report_mismatch($sformatf("register_select %0d, expected %0d", register_select,
                                    want.rs));
        if (bus_value !== want.val)
          report_mismatch($sformatf("bus_value %02h, expected %02h", bus_value, want.val));
        if (half !== want.hf)
          report_mismatch($sformatf("half %0d, expected %0d", half, want.hf));
        if (status !== want.st)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
        if (final_res !== want.fin)
          report_mismatch($sformatf("final_res %0d, expected %0d", final_res, want.fin));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [2:0] k;
    logic [4:0] c;
    logic [1:0] r;
    logic [7:0] ch;
    int         pick;
    int         counted;

    opening_reqs = '{
      '{KIND_REFRESH,    5'd0,  2'd0, 8'h00,        PREDICTED, STATUS_XFER},
      '{KIND_INIT,       5'd0,  2'd0, 8'h00,        PREDICTED, STATUS_XFER},
      '{KIND_SET_CURSOR, 5'd16, 2'd0, 8'h00,        ONE_FLAG,  STATUS_COL_OOR},
      '{KIND_PUT,        5'd0,  2'd0, 8'h41,        NO_WORDS,  STATUS_XFER},
      '{KIND_SET_CURSOR, 5'd0,  2'd0, 8'h00,        NO_WORDS,  STATUS_XFER},
      '{KIND_PUT,        5'd0,  2'd0, 8'hFF,        NO_WORDS,  STATUS_XFER},
      '{KIND_PUT,        5'd0,  2'd0, 8'h00,        NO_WORDS,  STATUS_XFER},
      '{KIND_PUT,        5'd0,  2'd0, CHAR_NEWLINE, NO_WORDS,  STATUS_XFER},
      '{KIND_PUT,        5'd0,  2'd0, 8'h42,        NO_WORDS,  STATUS_XFER},
      '{KIND_SET_CURSOR, 5'd15, 2'd1, 8'h00,        NO_WORDS,  STATUS_XFER},
      '{KIND_PUT,        5'd0,  2'd0, 8'h5A,        NO_WORDS,  STATUS_XFER},
      '{KIND_PUT,        5'd0,  2'd0, 8'h51,        ONE_FLAG,  STATUS_PAST_END},
      '{KIND_PUT,        5'd0,  2'd0, CHAR_NEWLINE, NO_WORDS,  STATUS_XFER},
      '{KIND_SET_CURSOR, 5'd0,  2'd3, 8'h00,        NO_WORDS,  STATUS_XFER},
      '{KIND_PUT,        5'd0,  2'd0, CHAR_NEWLINE, NO_WORDS,  STATUS_XFER},
      '{KIND_PUT,        5'd0,  2'd0, 8'h78,        ONE_FLAG,  STATUS_PAST_END},
      '{KIND_REFRESH,    5'd0,  2'd1, 8'h00,        PREDICTED, STATUS_XFER},
      '{KIND_REFRESH,    5'd0,  2'd2, 8'h00,        NO_WORDS,  STATUS_XFER},
      '{KIND_REFRESH,    5'd0,  2'd3, 8'h00,        NO_WORDS,  STATUS_XFER},
      '{KIND_UNUSED_LO,  5'd31, 2'd3, 8'hFF,        NO_WORDS,  STATUS_XFER},
      '{KIND_UNUSED_MID, 5'd31, 2'd3, 8'hFF,        NO_WORDS,  STATUS_XFER},
      '{KIND_UNUSED_HI,  5'd31, 2'd3, 8'hFF,        NO_WORDS,  STATUS_XFER},
      '{KIND_CLEAR,      5'd31, 2'd3, 8'hFF,        NO_WORDS,  STATUS_XFER},
      '{KIND_REFRESH,    5'd0,  2'd0, 8'h00,        PREDICTED, STATUS_XFER},
      '{KIND_SET_CURSOR, 5'd31, 2'd3, 8'h00,        ONE_FLAG,  STATUS_COL_OOR}
    };
    // out-of-range settings are folded to the nearest legal value by the block
    phases = '{
      '{5'd20, 3'd4, 1'b1},
      '{5'd1,  3'd1, 1'b0},
      '{5'd31, 3'd7, 1'b0},
      '{5'd0,  3'd0, 1'b1},
      '{5'd8,  3'd3, 1'b1},
      '{5'd20, 3'd4, 1'b0},
      '{5'd12, 3'd2, 1'b1}
    };
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_reqs[i])
      send_request(opening_reqs[i].kind, opening_reqs[i].column, opening_reqs[i].row,
                   opening_reqs[i].character, opening_reqs[i].typed, opening_reqs[i].flag);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_and_settle();
      write_reg(REG_COLUMNS, phases[p].cols);
      write_reg(REG_ROWS, {2'b00, phases[p].rows});
      write_reg(REG_BUS4, {4'h0, phases[p].four});
      cfg_write <= 1'b0;
      calm <= (p == CALM_PHASE);
      // first word lands on the old cursor, which may now be beyond the row width
      send_request(KIND_PUT, 5'd0, 2'd0, 8'($urandom_range(8'h21, 8'h7E)), PREDICTED,
                   STATUS_XFER);
      counted = 1;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        c    = 5'($urandom_range(0, 31));
        r    = 2'($urandom_range(0, 3));
        ch   = 8'($urandom_range(0, 255));
        if (pick < 3) k = KIND_INIT;
        else if (pick < 8) k = KIND_CLEAR;
        else if (pick < 28) k = KIND_SET_CURSOR;
        else if (pick < 73) k = KIND_PUT;
        else if (pick < 95) k = KIND_REFRESH;
        else k = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        if (k == KIND_SET_CURSOR && $urandom_range(0, 99) < 80)
          c = 5'($urandom_range(0, cols_in_use() - 1));
        if (k == KIND_PUT && $urandom_range(0, 99) < 12) ch = CHAR_NEWLINE;
        send_request(k, c, r, ch, PREDICTED, STATUS_XFER);
        if (k <= KIND_REFRESH) counted++;
      end
    end

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/clcd_pkg.sv
rtl/core/clcd_ram.sv
rtl/core/char_lcd_buffer_controller_top.sv
tb/sv/char_lcd_buffer_controller_top_tb.sv
